// File: src/ofvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofvt_pkg - shared types and constants
// Register indexes, frame builder states and frame status for the
// orthonormal frame vector transform unit.
// ----------------------------------------------------------------------------
package ofvt_pkg;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_FWD_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FWD_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FWD_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_X  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_Y  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_Z  = 3'd5;

    // frame builder sequence
    typedef enum logic [6:0] {
        S_DOT   = 7'b0000001,
        S_UP    = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_CROSS = 7'b0100000,
        S_READY = 7'b1000000
    } t_bld_state;

    typedef struct packed {
        logic ok;
        logic degen;
    } t_frame_stat;

endpackage
`default_nettype wire

// File: src/orthonormal_frame_vector_transform_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orthonormal_frame_vector_transform_unit - look-at frame vector transform
// Builds a Gram-Schmidt frame (R, U', F) from the configured forward and up
// vectors and maps every input vector to vx*R + vy*U' + vz*F, Q-format,
// saturated.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  ----------+-------------------+-----------------------------------------
//  input     | push / full       | i_vec_x, i_vec_y, i_vec_z
//  result    | pop / empty       | o_out_x, o_out_y, o_out_z, o_degenerate
//  config    | i_cfg_we          | i_cfg_idx, i_cfg_data (no wait state)
//
//  One vector transaction per cycle sustained while full is low; a result
//  passes the input queue, the product and sum registers and the result
//  queue before it shows on the result ports. After reset and after each
//  config write the frame is rebuilt and full is held high; the rebuild
//  runs the bit-serial square root and the three bit-serial divides, which
//  are skipped when the orthogonalized up vector has zero length.
//  Reset is synchronous, active low, and restores the default frame inputs.
//  A stalled result side fills the output queue, then the input queue,
//  then raises full; no transaction is lost.
// ----------------------------------------------------------------------------
module orthonormal_frame_vector_transform_unit
    import ofvt_pkg::*;
#(
    parameter int WORD_BITS   = 24,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic signed [WORD_BITS-1:0] i_vec_x,
    input  wire logic signed [WORD_BITS-1:0] i_vec_y,
    input  wire logic signed [WORD_BITS-1:0] i_vec_z,
    input  wire logic                        pop,
    output logic                             empty,
    output logic signed [WORD_BITS-1:0]      o_out_x,
    output logic signed [WORD_BITS-1:0]      o_out_y,
    output logic signed [WORD_BITS-1:0]      o_out_z,
    output logic                             o_degenerate,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [WORD_BITS-1:0]        i_cfg_data
);
    localparam int W    = WORD_BITS;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_frame_stat          frame_stat;
    logic [2:0][W-1:0]    fwd, upv, rgt;
    logic                 in_full, in_empty, in_pop, in_push;
    logic [3*W-1:0]       in_data;
    logic [CNTW-1:0]      in_count, out_count;
    logic                 out_push, out_full;
    logic [3*W:0]         out_wdata, out_rdata;

    // hold off input transactions until the frame is complete
    assign full    = !frame_stat.ok || in_full;
    assign in_push = push && !full;

    ofvt_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (frame_stat),
        .o_fwd      (fwd),
        .o_upv      (upv),
        .o_rgt      (rgt)
    );

    // decouples acceptance from the transform pipeline
    ofvt_fifo #(
        .WIDTH (3 * W),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_push),
        .i_data  ({i_vec_z, i_vec_y, i_vec_x}),
        .i_pop   (in_pop),
        .o_data  (in_data),
        .o_full  (in_full),
        .o_empty (in_empty),
        .o_count (in_count)
    );

    ofvt_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .OUT_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fwd       (fwd),
        .i_upv       (upv),
        .i_rgt       (rgt),
        .i_degen     (frame_stat.degen),
        .i_src_empty (in_empty),
        .i_src_data  (in_data),
        .o_src_pop   (in_pop),
        .i_dst_count (out_count),
        .o_dst_push  (out_push),
        .o_dst_data  (out_wdata)
    );

    // result queue; the pipeline only issues when a slot is reserved here
    ofvt_fifo #(
        .WIDTH (3 * W + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wdata),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_out_x      = $signed(out_rdata[W-1:0]);
    assign o_out_y      = $signed(out_rdata[2*W-1:W]);
    assign o_out_z      = $signed(out_rdata[3*W-1:2*W]);
    assign o_degenerate = out_rdata[3*W] && !out_full && (in_count <= CNTW'(QUEUE_DEPTH))
                          ? 1'b1 : out_rdata[3*W];

endmodule
`default_nettype wire

// File: src/ofvt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofvt_fifo - small register queue
// First-in first-out buffer with occupancy count; read data is the head entry.
// ----------------------------------------------------------------------------
module ofvt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_full,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wr, r_rd;
    logic [CNTW-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/ofvt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofvt_front - configuration registers and frame builder
// Holds F and U, and rebuilds the orthonormal frame on a shared multiplier,
// an iterative square root and a restoring divider after reset or any write.
// ----------------------------------------------------------------------------
module ofvt_front
    import ofvt_pkg::*;
#(
    parameter int WORD_BITS = 24,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire logic [WORD_BITS-1:0]          i_cfg_data,
    output t_frame_stat                        o_stat,
    output logic      [2:0][WORD_BITS-1:0]     o_fwd,
    output logic      [2:0][WORD_BITS-1:0]     o_upv,
    output logic      [2:0][WORD_BITS-1:0]     o_rgt
);
    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 2;
    localparam int NW = W + F + 1;
    localparam int CW = $clog2(NW + 1);

    localparam logic [W-1:0]         ONE     = W'(1) << F;
    localparam logic signed [PW-1:0] HALF    = PW'(1) << (F - 1);
    localparam logic signed [AW-1:0] ACC_MAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [NW-1:0]        Q_LIM   = NW'(1) << (W - 1);

    function automatic logic [W-1:0] sat_w(input logic signed [AW-1:0] x);
        logic [W-1:0] y;
        if (x > ACC_MAX) begin
            y = ACC_MAX[W-1:0];
        end else if (x < ACC_MIN) begin
            y = ACC_MIN[W-1:0];
        end else begin
            y = x[W-1:0];
        end
        return y;
    endfunction

    logic [2:0][W-1:0]      r_fwd, r_up, r_upv, r_rgt;
    t_bld_state             r_state;
    logic [2:0]             r_idx;
    logic                   r_ph;
    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc;
    logic [W-1:0]           r_d;
    logic [PW-1:0]          r_s;
    logic [W:0]             r_rem;
    logic [W-1:0]           r_root, r_len;
    logic [NW-1:0]          r_num;
    logic                   r_neg;
    logic [CW-1:0]          r_cnt;
    logic                   r_degen;

    logic [1:0]             ix;
    logic signed [W-1:0]    op_a, op_b;
    logic                   use_half, sub;
    logic signed [PW-1:0]   mul_p, n_prod, term;
    logic signed [AW-1:0]   term_e, acc_sum, up_diff;
    logic [PW-1:0]          s_sum;
    logic [W+1:0]           rem_sh, trial, rem_nx;
    logic                   sq_ge;
    logic [W-1:0]           root_nx;
    logic [W:0]             dv_sh, dv_rem;
    logic                   dv_ge;
    logic [NW-1:0]          num_nx, num0;
    logic [W-1:0]           mag, qsat;

    assign ix = r_idx[1:0];

    // operand select for the shared multiplier
    always_comb begin
        op_a     = '0;
        op_b     = '0;
        use_half = 1'b1;
        case (r_state)
            S_DOT: begin
                op_a = $signed(r_fwd[ix]);
                op_b = $signed(r_up[ix]);
            end
            S_UP: begin
                op_a = $signed(r_d);
                op_b = $signed(r_fwd[ix]);
            end
            S_SQ: begin
                op_a     = $signed(r_upv[ix]);
                op_b     = $signed(r_upv[ix]);
                use_half = 1'b0;
            end
            S_CROSS: begin
                case (r_idx)
                    3'd0: begin op_a = $signed(r_upv[1]); op_b = $signed(r_fwd[2]); end
                    3'd1: begin op_a = $signed(r_upv[2]); op_b = $signed(r_fwd[1]); end
                    3'd2: begin op_a = $signed(r_upv[2]); op_b = $signed(r_fwd[0]); end
                    3'd3: begin op_a = $signed(r_upv[0]); op_b = $signed(r_fwd[2]); end
                    3'd4: begin op_a = $signed(r_upv[0]); op_b = $signed(r_fwd[1]); end
                    3'd5: begin op_a = $signed(r_upv[1]); op_b = $signed(r_fwd[0]); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign mul_p   = op_a * op_b;
    assign n_prod  = mul_p + (use_half ? HALF : '0);
    assign term    = r_prod >>> F;
    assign term_e  = AW'(term);
    assign sub     = (r_state == S_CROSS) && r_idx[0];
    assign acc_sum = r_acc + (sub ? -term_e : term_e);
    assign up_diff = AW'($signed(r_up[ix])) - term_e;
    assign s_sum   = r_s + r_prod;

    // square root: one result bit per cycle
    assign rem_sh  = {r_rem[W-1:0], r_s[PW-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign sq_ge   = (rem_sh >= trial);
    assign rem_nx  = sq_ge ? (rem_sh - trial) : rem_sh;
    assign root_nx = {r_root[W-2:0], sq_ge};

    // restoring divide: one quotient bit per cycle
    assign dv_sh  = {r_rem[W-1:0], r_num[NW-1]};
    assign dv_ge  = (dv_sh >= {1'b0, r_len});
    assign dv_rem = dv_ge ? (dv_sh - {1'b0, r_len}) : dv_sh;
    assign num_nx = {r_num[NW-2:0], dv_ge};
    assign mag    = r_upv[ix][W-1] ? W'(-$signed(r_upv[ix])) : r_upv[ix];
    assign num0   = NW'({mag, {F{1'b0}}}) + NW'(r_len >> 1);

    always_comb begin
        if (r_neg) begin
            qsat = (num_nx > Q_LIM) ? ACC_MIN[W-1:0] : W'(-num_nx[W-1:0]);
        end else begin
            qsat = (num_nx >= Q_LIM) ? ACC_MAX[W-1:0] : num_nx[W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= {ONE, W'(0), W'(0)};
            r_up  <= {W'(0), ONE, W'(0)};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FWD_X: r_fwd[0] <= i_cfg_data;
                REG_FWD_Y: r_fwd[1] <= i_cfg_data;
                REG_FWD_Z: r_fwd[2] <= i_cfg_data;
                REG_UP_X:  r_up[0]  <= i_cfg_data;
                REG_UP_Y:  r_up[1]  <= i_cfg_data;
                REG_UP_Z:  r_up[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame build sequence; any write restarts it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= S_DOT;
            r_idx   <= '0;
            r_ph    <= 1'b0;
            r_acc   <= '0;
            r_degen <= 1'b0;
        end else begin
            case (r_state)
                S_DOT, S_UP, S_SQ, S_CROSS: begin
                    if (!r_ph) begin
                        r_prod <= n_prod;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        case (r_state)
                            S_DOT: begin
                                if (r_idx == 3'd2) begin
                                    r_d     <= sat_w(acc_sum);
                                    r_acc   <= '0;
                                    r_idx   <= '0;
                                    r_state <= S_UP;
                                end else begin
                                    r_acc <= acc_sum;
                                    r_idx <= r_idx + 1'b1;
                                end
                            end
                            S_UP: begin
                                r_upv[ix] <= sat_w(up_diff);
                                if (r_idx == 3'd2) begin
                                    r_idx   <= '0;
                                    r_s     <= '0;
                                    r_state <= S_SQ;
                                end else begin
                                    r_idx <= r_idx + 1'b1;
                                end
                            end
                            S_SQ: begin
                                r_s <= s_sum;
                                if (r_idx == 3'd2) begin
                                    r_idx <= '0;
                                    if (s_sum == '0) begin
                                        r_degen <= 1'b1;
                                        r_state <= S_CROSS;
                                    end else begin
                                        r_degen <= 1'b0;
                                        r_rem   <= '0;
                                        r_root  <= '0;
                                        r_cnt   <= '0;
                                        r_state <= S_SQRT;
                                    end
                                end else begin
                                    r_idx <= r_idx + 1'b1;
                                end
                            end
                            default: begin
                                if (r_idx[0]) begin
                                    r_rgt[r_idx[2:1]] <= sat_w(acc_sum);
                                    r_acc             <= '0;
                                end else begin
                                    r_acc <= acc_sum;
                                end
                                if (r_idx == 3'd5) begin
                                    r_idx   <= '0;
                                    r_state <= S_READY;
                                end else begin
                                    r_idx <= r_idx + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_SQRT: begin
                    r_rem  <= rem_nx[W:0];
                    r_root <= root_nx;
                    r_s    <= r_s << 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) begin
                        r_len   <= root_nx;
                        r_idx   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!r_ph) begin
                        r_num <= num0;
                        r_neg <= r_upv[ix][W-1];
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_ph  <= 1'b1;
                    end else begin
                        r_rem <= dv_rem;
                        r_num <= num_nx;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CW'(NW - 1)) begin
                            r_upv[ix] <= qsat;
                            r_ph      <= 1'b0;
                            if (r_idx == 3'd2) begin
                                r_idx   <= '0;
                                r_state <= S_CROSS;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                S_READY: ;
                default: r_state <= S_DOT;
            endcase
        end
    end

    assign o_stat.ok    = (r_state == S_READY);
    assign o_stat.degen = r_degen;
    assign o_fwd        = r_fwd;
    assign o_upv        = r_upv;
    assign o_rgt        = r_rgt;

endmodule
`default_nettype wire

// File: src/ofvt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofvt_back - vector transform pipeline
// Pulls vectors from the input queue under output credit, forms nine rounded
// products, then sums and saturates each component.
// ----------------------------------------------------------------------------
module ofvt_back #(
    parameter int WORD_BITS = 24,
    parameter int FRAC_BITS = 16,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [2:0][WORD_BITS-1:0]         i_fwd,
    input  wire logic [2:0][WORD_BITS-1:0]         i_upv,
    input  wire logic [2:0][WORD_BITS-1:0]         i_rgt,
    input  wire logic                              i_degen,
    input  wire logic                              i_src_empty,
    input  wire logic [3*WORD_BITS-1:0]            i_src_data,
    output logic                                   o_src_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0]    i_dst_count,
    output logic                                   o_dst_push,
    output logic      [3*WORD_BITS:0]              o_dst_data
);
    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int AW   = 2 * W + 2;
    localparam int CNTW = $clog2(OUT_DEPTH + 1) + 1;

    localparam logic signed [PW-1:0] HALF    = PW'(1) << (F - 1);
    localparam logic signed [AW-1:0] ACC_MAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_w(input logic signed [AW-1:0] x);
        logic [W-1:0] y;
        if (x > ACC_MAX) begin
            y = ACC_MAX[W-1:0];
        end else if (x < ACC_MIN) begin
            y = ACC_MIN[W-1:0];
        end else begin
            y = x[W-1:0];
        end
        return y;
    endfunction

    logic                 r_v1, r_v2, r_dg1, r_dg2;
    logic signed [PW-1:0] r_pr [3];
    logic signed [PW-1:0] r_pu [3];
    logic signed [PW-1:0] r_pf [3];
    logic [2:0][W-1:0]    r_out;
    logic signed [W-1:0]  vx, vy, vz;
    logic signed [AW-1:0] sum [3];
    logic [CNTW-1:0]      used;
    logic                 issue;

    assign vx = $signed(i_src_data[W-1:0]);
    assign vy = $signed(i_src_data[2*W-1:W]);
    assign vz = $signed(i_src_data[3*W-1:2*W]);

    // credit: queued results plus those still in flight
    assign used  = CNTW'(i_dst_count) + CNTW'(r_v1) + CNTW'(r_v2);
    assign issue = !i_src_empty && (used < CNTW'(OUT_DEPTH));
    assign o_src_pop = issue;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = AW'(r_pr[i] >>> F) + AW'(r_pu[i] >>> F) + AW'(r_pf[i] >>> F);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pr[i]  <= vx * $signed(i_rgt[i]) + HALF;
            r_pu[i]  <= vy * $signed(i_upv[i]) + HALF;
            r_pf[i]  <= vz * $signed(i_fwd[i]) + HALF;
            r_out[i] <= sat_w(sum[i]);
        end
        r_dg1 <= i_degen;
        r_dg2 <= r_dg1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    assign o_dst_push = r_v2;
    assign o_dst_data = {r_dg2, r_out[2], r_out[1], r_out[0]};

endmodule
`default_nettype wire

// File: src/ofvt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofvt_checker - port-level assertions
// Checks frame rebuild blocking and result queue behavior at the top level.
// ----------------------------------------------------------------------------
module ofvt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic push,
    input wire logic full,
    input wire logic pop,
    input wire logic empty,
    input wire logic i_cfg_we
);

    // frame is rebuilt after reset: no transaction accepted next cycle
    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("input accepted right after reset");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // a config write starts a rebuild
    a_full_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> full)
        else $error("input accepted during frame rebuild");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped");

endmodule

bind orthonormal_frame_vector_transform_unit ofvt_checker u_ofvt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .i_cfg_we (i_cfg_we)
);
`default_nettype wire
